// File: hw/rtl/gb5_pkg.sv
// gb5_pkg.sv: constants, types and the tap weight table of the 5x5 Gaussian blur stream core.
// It has no dependencies; every other file in hw/rtl uses it through scoped names.
package gb5_pkg;

    // Kernel and image geometry.
    localparam int KSIZE          = 5;
    localparam int HALF           = KSIZE / 2;
    localparam int LINES          = KSIZE - 1;
    localparam int LINE_SEL_W     = $clog2(LINES);
    localparam int MAX_WIDTH      = 1024;
    localparam int COL_W          = $clog2(MAX_WIDTH);
    localparam int MIN_WIDTH_LOG2 = 2;
    localparam int MAX_WIDTH_LOG2 = COL_W;
    localparam int ROW_W          = 11;
    localparam int HEIGHT_CAP     = 1024;
    localparam int COUNT_W        = 20;
    localparam int TOTAL_W        = COUNT_W + 1;

    // Datapath widths.
    localparam int PIX_W       = 8;
    localparam int WGT_W       = 16;
    localparam int PROD_W      = PIX_W + WGT_W;
    localparam int ROWSUM_W    = PROD_W + 3;
    localparam int SUM_W       = PROD_W + 5;
    localparam int RES_W       = 16;
    localparam int ROUND_SHIFT = 8;
    localparam int NUM_WEIGHTS = 6;

    // Output queue.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

    // Register port.
    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int ADDR_W    = $clog2(REG_COUNT * 4);
    localparam int DATA_W    = 32;

    typedef logic [PIX_W-1:0]                        t_pix;
    typedef logic [NUM_WEIGHTS-1:0][WGT_W-1:0]       t_weights;
    typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0]  t_win;
    typedef logic [LINES-1:0][PIX_W-1:0]             t_lines;
    typedef logic [2:0]                              t_wsel;
    typedef logic [REG_IDX_W-1:0]                    t_reg_idx;

    // Item as it leaves the input register.
    typedef struct packed {
        logic              valid;
        logic              res;
        logic              last;
        logic              mode;
        t_pix              pixel;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_item;

    // Effective frame geometry.
    typedef struct packed {
        logic [COL_W-1:0]  width_m1;
        logic [ROW_W-1:0]  height;
    } t_geom;

    // Control that travels with a window toward the multipliers.
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [KSIZE-1:0]  mask;
    } t_tap_ctl;

    typedef struct packed {
        logic [RES_W-1:0]  blurred;
        logic              last;
    } t_result;

    // Input item kinds.
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // Weight slots, by squared distance from the center tap.
    localparam t_wsel WSEL_CENTER = 3'd0;
    localparam t_wsel WSEL_D1     = 3'd1;
    localparam t_wsel WSEL_D2     = 3'd2;
    localparam t_wsel WSEL_D4     = 3'd3;
    localparam t_wsel WSEL_D5     = 3'd4;
    localparam t_wsel WSEL_D8     = 3'd5;

    // Weight slot of each tap, [row][column].
    localparam t_wsel TAP_WSEL [KSIZE][KSIZE] = '{
        '{WSEL_D8, WSEL_D5, WSEL_D4,     WSEL_D5, WSEL_D8},
        '{WSEL_D5, WSEL_D2, WSEL_D1,     WSEL_D2, WSEL_D5},
        '{WSEL_D4, WSEL_D1, WSEL_CENTER, WSEL_D1, WSEL_D4},
        '{WSEL_D5, WSEL_D2, WSEL_D1,     WSEL_D2, WSEL_D5},
        '{WSEL_D8, WSEL_D5, WSEL_D4,     WSEL_D5, WSEL_D8}
    };

    // Register indexes.
    localparam t_reg_idx REG_WIDTH_LOG2    = 3'd0;
    localparam t_reg_idx REG_HEIGHT_ROWS   = 3'd1;
    localparam t_reg_idx REG_WEIGHT_CENTER = 3'd2;
    localparam t_reg_idx REG_WEIGHT_D1     = 3'd3;
    localparam t_reg_idx REG_WEIGHT_D2     = 3'd4;
    localparam t_reg_idx REG_WEIGHT_D4     = 3'd5;
    localparam t_reg_idx REG_WEIGHT_D5     = 3'd6;
    localparam t_reg_idx REG_WEIGHT_D8     = 3'd7;

    // Register reset values.
    localparam logic [3:0]       RST_WIDTH_LOG2  = 4'd9;
    localparam logic [ROW_W-1:0] RST_HEIGHT_ROWS = 11'd512;
    localparam t_weights         RST_WEIGHTS     = '{
        16'd194, 16'd872, 16'd1437, 16'd3907, 16'd6443, 16'd10624
    };

endpackage

// File: hw/rtl/gaussian_blur_5x5_stream_core.sv
// gaussian_blur_5x5_stream_core.sv: top level of the streaming 5x5 Gaussian blur.
// Depends on gb5_pkg, gb5_line_buffer, gb5_window, gb5_mac and gb5_out_fifo.
//
// Usage. Grayscale pixels enter in raster order on the input channel (i_valid,
// o_stall, i_mode, i_pixel); a transaction completes on a rising edge with
// i_valid high and o_stall low. Blurred Q8.8 pixels leave on the output channel
// (o_valid, i_stall, o_blurred, o_frame_last) under the same rule. Results lag
// the stream by two rows plus two pixels, so after the frame's last pixel the
// source sends flush transactions (i_mode high) until o_frame_last is seen.
// Throughput is one transaction per cycle while o_stall is low: the input
// register, the window, the 25 multipliers and the adders form a five-register
// pipeline with no loop back into itself before a result enters the queue.
// When the receiver stalls, finished results collect in an eight-entry queue;
// o_stall rises only once the queue and the results still in the pipeline
// would fill it, and it comes from registers only, never from i_stall.
// Reset clears the position counters, the window, the pipeline and the queue,
// and loads the default 512x512 geometry and Gaussian weights. The line
// memories are not cleared: a frame only reads rows it has already written.
// Registers must be written through the APB port only while the stream is idle;
// the block does not enforce this. A width or height write restarts the frame.
module gaussian_blur_5x5_stream_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_mode,
    input  logic [gb5_pkg::PIX_W-1:0]     i_pixel,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [gb5_pkg::RES_W-1:0]     o_blurred,
    output logic                          o_frame_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gb5_pkg::ADDR_W-1:0]    paddr,
    input  logic [gb5_pkg::DATA_W-1:0]    pwdata,
    output logic [gb5_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    // Configuration registers.
    logic [3:0]                   r_width_log2;
    logic [gb5_pkg::ROW_W-1:0]    r_height_rows;
    gb5_pkg::t_weights            r_weights;

    // Stream position and frame progress.
    logic [gb5_pkg::COL_W-1:0]    r_in_col, n_in_col;
    logic [gb5_pkg::ROW_W-1:0]    r_in_row, n_in_row;
    logic [gb5_pkg::COUNT_W-1:0]  r_out_cnt, n_out_cnt;

    // Results queued or still in the pipeline.
    logic [gb5_pkg::OCC_W-1:0]    r_occ, n_occ;

    gb5_pkg::t_item               r_item, n_item;

    logic [3:0]                   w_eff_log2;
    logic [gb5_pkg::ROW_W-1:0]    w_height;
    logic [gb5_pkg::TOTAL_W-1:0]  w_total;
    gb5_pkg::t_geom               w_geom;
    logic                         w_draining, w_take, w_in_acc, w_item;
    logic                         w_past_lag, w_has_res, w_last;
    logic                         w_out_acc;
    logic                         w_cfg_wr, w_geom_wr;
    gb5_pkg::t_reg_idx            w_cfg_idx;

    gb5_pkg::t_lines              w_lines;
    gb5_pkg::t_win                w_win;
    gb5_pkg::t_tap_ctl            w_tap_ctl;
    logic                         w_res_valid;
    gb5_pkg::t_result             w_res;
    gb5_pkg::t_result             w_head;

    // ---------------------------------------------------------------------
    // Effective geometry: width is a power of two from 4 to 1024 pixels and
    // the height runs from 1 to 1024 rows.
    // ---------------------------------------------------------------------
    always_comb begin
        if (r_width_log2 < 4'(gb5_pkg::MIN_WIDTH_LOG2)) begin
            w_eff_log2 = 4'(gb5_pkg::MIN_WIDTH_LOG2);
        end else if (r_width_log2 > 4'(gb5_pkg::MAX_WIDTH_LOG2)) begin
            w_eff_log2 = 4'(gb5_pkg::MAX_WIDTH_LOG2);
        end else begin
            w_eff_log2 = r_width_log2;
        end

        if (r_height_rows == '0) begin
            w_height = gb5_pkg::ROW_W'(1);
        end else if (r_height_rows > gb5_pkg::ROW_W'(gb5_pkg::HEIGHT_CAP)) begin
            w_height = gb5_pkg::ROW_W'(gb5_pkg::HEIGHT_CAP);
        end else begin
            w_height = r_height_rows;
        end
    end

    assign w_geom.width_m1 = ~({gb5_pkg::COL_W{1'b1}} << w_eff_log2);
    assign w_geom.height   = w_height;
    assign w_total         = gb5_pkg::TOTAL_W'(w_height) << w_eff_log2;

    // ---------------------------------------------------------------------
    // Input side. Pixels are taken until the frame's last row is in, then
    // only flush transactions; the wrong kind completes but changes nothing.
    // ---------------------------------------------------------------------
    assign o_stall    = (r_occ >= gb5_pkg::OCC_W'(gb5_pkg::FIFO_DEPTH));
    assign w_in_acc   = i_valid && !o_stall;
    assign w_draining = (r_in_row >= w_height);
    assign w_take     = (i_mode == gb5_pkg::MODE_FLUSH) ? w_draining : !w_draining;
    assign w_item     = w_in_acc && w_take;

    // A result is due once two rows and two pixels have gone by, until the
    // frame's pixel count is reached.
    assign w_past_lag = (r_in_row > gb5_pkg::ROW_W'(gb5_pkg::HALF)) ||
                        ((r_in_row == gb5_pkg::ROW_W'(gb5_pkg::HALF)) &&
                         (r_in_col >= gb5_pkg::COL_W'(gb5_pkg::HALF)));
    assign w_has_res  = w_past_lag && (gb5_pkg::TOTAL_W'(r_out_cnt) < w_total);
    assign w_last     = (gb5_pkg::TOTAL_W'(r_out_cnt) == (w_total - gb5_pkg::TOTAL_W'(1)));

    // Register port decode.
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[gb5_pkg::ADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_geom_wr = w_cfg_wr && ((w_cfg_idx == gb5_pkg::REG_WIDTH_LOG2) ||
                                    (w_cfg_idx == gb5_pkg::REG_HEIGHT_ROWS));

    // Position counters. The frame restarts after its last result and on any
    // geometry write.
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_cnt = r_out_cnt;
        if (w_item) begin
            if (r_in_col == w_geom.width_m1) begin
                n_in_col = '0;
                n_in_row = r_in_row + gb5_pkg::ROW_W'(1);
            end else begin
                n_in_col = r_in_col + gb5_pkg::COL_W'(1);
            end
            if (w_has_res) begin
                if (w_last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_cnt = '0;
                end else begin
                    n_out_cnt = r_out_cnt + gb5_pkg::COUNT_W'(1);
                end
            end
        end
        if (w_geom_wr) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_cnt = '0;
        end
    end

    // The occupancy counts a result from the moment its transaction completes
    // until it leaves on the output channel.
    assign w_out_acc = o_valid && !i_stall;

    always_comb begin
        n_occ = r_occ;
        if ((w_item && w_has_res) && !w_out_acc) begin
            n_occ = r_occ + gb5_pkg::OCC_W'(1);
        end else if (!(w_item && w_has_res) && w_out_acc) begin
            n_occ = r_occ - gb5_pkg::OCC_W'(1);
        end
    end

    always_comb begin
        n_item.valid = w_item;
        n_item.res   = w_has_res;
        n_item.last  = w_last;
        n_item.mode  = i_mode;
        n_item.pixel = i_pixel;
        n_item.row   = r_in_row;
        n_item.col   = r_in_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_cnt <= '0;
            r_occ     <= '0;
            r_item    <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_cnt <= n_out_cnt;
            r_occ     <= n_occ;
            r_item    <= n_item;
        end
    end

    // Configuration writes; the index comes from the word address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_log2  <= gb5_pkg::RST_WIDTH_LOG2;
            r_height_rows <= gb5_pkg::RST_HEIGHT_ROWS;
            r_weights     <= gb5_pkg::RST_WEIGHTS;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                gb5_pkg::REG_WIDTH_LOG2: begin
                    r_width_log2 <= pwdata[3:0];
                end
                gb5_pkg::REG_HEIGHT_ROWS: begin
                    r_height_rows <= pwdata[gb5_pkg::ROW_W-1:0];
                end
                gb5_pkg::REG_WEIGHT_CENTER: begin
                    r_weights[gb5_pkg::WSEL_CENTER] <= pwdata[gb5_pkg::WGT_W-1:0];
                end
                gb5_pkg::REG_WEIGHT_D1: begin
                    r_weights[gb5_pkg::WSEL_D1] <= pwdata[gb5_pkg::WGT_W-1:0];
                end
                gb5_pkg::REG_WEIGHT_D2: begin
                    r_weights[gb5_pkg::WSEL_D2] <= pwdata[gb5_pkg::WGT_W-1:0];
                end
                gb5_pkg::REG_WEIGHT_D4: begin
                    r_weights[gb5_pkg::WSEL_D4] <= pwdata[gb5_pkg::WGT_W-1:0];
                end
                gb5_pkg::REG_WEIGHT_D5: begin
                    r_weights[gb5_pkg::WSEL_D5] <= pwdata[gb5_pkg::WGT_W-1:0];
                end
                gb5_pkg::REG_WEIGHT_D8: begin
                    r_weights[gb5_pkg::WSEL_D8] <= pwdata[gb5_pkg::WGT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (w_cfg_idx)
            gb5_pkg::REG_WIDTH_LOG2:    prdata = gb5_pkg::DATA_W'(r_width_log2);
            gb5_pkg::REG_HEIGHT_ROWS:   prdata = gb5_pkg::DATA_W'(r_height_rows);
            gb5_pkg::REG_WEIGHT_CENTER: prdata = gb5_pkg::DATA_W'(r_weights[gb5_pkg::WSEL_CENTER]);
            gb5_pkg::REG_WEIGHT_D1:     prdata = gb5_pkg::DATA_W'(r_weights[gb5_pkg::WSEL_D1]);
            gb5_pkg::REG_WEIGHT_D2:     prdata = gb5_pkg::DATA_W'(r_weights[gb5_pkg::WSEL_D2]);
            gb5_pkg::REG_WEIGHT_D4:     prdata = gb5_pkg::DATA_W'(r_weights[gb5_pkg::WSEL_D4]);
            gb5_pkg::REG_WEIGHT_D5:     prdata = gb5_pkg::DATA_W'(r_weights[gb5_pkg::WSEL_D5]);
            gb5_pkg::REG_WEIGHT_D8:     prdata = gb5_pkg::DATA_W'(r_weights[gb5_pkg::WSEL_D8]);
            default:                    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Datapath: line memories are read as the transaction completes, the
    // window shifts in the following cycle, then multiply, row sums and rounding.
    // ---------------------------------------------------------------------
    gb5_line_buffer u_line_buffer (
        .i_clk     (i_clk),
        .i_rd_en   (w_item),
        .i_addr    (r_in_col),
        .i_wr_en   (w_item && (i_mode == gb5_pkg::MODE_PIXEL)),
        .i_wr_line (r_in_row[gb5_pkg::LINE_SEL_W-1:0]),
        .i_wr_data (i_pixel),
        .o_rd_data (w_lines)
    );

    gb5_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (r_item),
        .i_lines (w_lines),
        .i_geom  (w_geom),
        .o_win   (w_win),
        .o_ctl   (w_tap_ctl)
    );

    gb5_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_win     (w_win),
        .i_ctl     (w_tap_ctl),
        .i_weights (r_weights),
        .o_valid   (w_res_valid),
        .o_result  (w_res)
    );

    gb5_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_valid),
        .i_wdata (w_res),
        .i_rd    (w_out_acc),
        .o_valid (o_valid),
        .o_rdata (w_head)
    );

    assign o_blurred    = w_head.blurred;
    assign o_frame_last = w_head.last;

`ifndef ASSERT_OFF
    // The credit count never promises more results than the queue can hold.
    a_occ_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= gb5_pkg::OCC_W'(gb5_pkg::FIFO_DEPTH))
        else $error("result occupancy exceeds the output queue depth");

    // A result on the output is always covered by the credit count.
    a_valid_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_occ != '0))
        else $error("output valid without an outstanding result");

    // A transaction that causes a result raises the count unless one leaves.
    a_credit_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_item && w_has_res && !w_out_acc) |=> (r_occ == $past(r_occ) + gb5_pkg::OCC_W'(1)))
        else $error("result credit did not follow an accepted transaction");
`endif

endmodule

// File: hw/rtl/gb5_line_buffer.sv
// gb5_line_buffer.sv: four line memories that hold the previous image rows.
// Depends on gb5_pkg for widths and the line count.
module gb5_line_buffer (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [gb5_pkg::COL_W-1:0]    i_addr,
    input  logic                         i_wr_en,
    input  logic [gb5_pkg::LINE_SEL_W-1:0] i_wr_line,
    input  gb5_pkg::t_pix                i_wr_data,
    output gb5_pkg::t_lines              o_rd_data
);

    // Every line is read at the column of the incoming item; the line that holds
    // the oldest row is overwritten at the same column and returns its old byte.
    for (genvar b = 0; b < gb5_pkg::LINES; b++) begin : g_line
        logic [gb5_pkg::PIX_W-1:0] r_mem [gb5_pkg::MAX_WIDTH];
        gb5_pkg::t_pix             r_rd;

        always_ff @(posedge i_clk) begin
            if (i_wr_en && (i_wr_line == gb5_pkg::LINE_SEL_W'(b))) begin
                r_mem[i_addr] <= i_wr_data;
            end
            if (i_rd_en) begin
                r_rd <= r_mem[i_addr];
            end
        end

        assign o_rd_data[b] = r_rd;
    end

endmodule

// File: hw/rtl/gb5_window.sv
// gb5_window.sv: 5x5 window register with row padding and the column edge mask.
// Depends on gb5_pkg; fed by the input register and gb5_line_buffer.
module gb5_window (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gb5_pkg::t_item    i_item,
    input  gb5_pkg::t_lines   i_lines,
    input  gb5_pkg::t_geom    i_geom,
    output gb5_pkg::t_win     o_win,
    output gb5_pkg::t_tap_ctl o_ctl
);

    gb5_pkg::t_win                                   r_win;
    gb5_pkg::t_tap_ctl                               r_ctl;
    gb5_pkg::t_tap_ctl                               n_ctl;
    logic [gb5_pkg::KSIZE-1:0][gb5_pkg::PIX_W-1:0]   w_col;
    logic [gb5_pkg::COL_W-1:0]                       w_center;

    // New column: rows above the frame or below its last row read as zero.
    always_comb begin
        for (int i = 0; i < gb5_pkg::LINES; i++) begin
            w_col[i] = '0;
            if ((i_item.row >= gb5_pkg::ROW_W'(gb5_pkg::LINES - i)) &&
                (({1'b0, i_item.row} + (gb5_pkg::ROW_W + 1)'(i)) <
                 ({1'b0, i_geom.height} + (gb5_pkg::ROW_W + 1)'(gb5_pkg::LINES)))) begin
                w_col[i] = i_lines[gb5_pkg::LINE_SEL_W'(
                    i_item.row[gb5_pkg::LINE_SEL_W-1:0] + gb5_pkg::LINE_SEL_W'(i))];
            end
        end
        w_col[gb5_pkg::KSIZE-1] = (i_item.mode == gb5_pkg::MODE_PIXEL) ? i_item.pixel : '0;
    end

    // Column of the output pixel; it wraps to the previous row near the left edge.
    always_comb begin
        if (i_item.col >= gb5_pkg::COL_W'(gb5_pkg::HALF)) begin
            w_center = i_item.col - gb5_pkg::COL_W'(gb5_pkg::HALF);
        end else begin
            w_center = i_geom.width_m1 + i_item.col - gb5_pkg::COL_W'(gb5_pkg::HALF - 1);
        end
    end

    always_comb begin
        n_ctl.valid = i_item.valid && i_item.res;
        n_ctl.last  = i_item.last;
        for (int j = 0; j < gb5_pkg::KSIZE; j++) begin
            n_ctl.mask[j] =
                (({2'b00, w_center} + (gb5_pkg::COL_W + 2)'(j)) >=
                 (gb5_pkg::COL_W + 2)'(gb5_pkg::HALF)) &&
                (({2'b00, w_center} + (gb5_pkg::COL_W + 2)'(j)) <
                 ({2'b00, i_geom.width_m1} + (gb5_pkg::COL_W + 2)'(gb5_pkg::HALF + 1)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
            if (i_item.valid) begin
                for (int i = 0; i < gb5_pkg::KSIZE; i++) begin
                    r_win[i] <= {w_col[i], r_win[i][gb5_pkg::KSIZE-1:1]};
                end
            end
        end
    end

    assign o_win = r_win;
    assign o_ctl = r_ctl;

endmodule

// File: hw/rtl/gb5_mac.sv
// gb5_mac.sv: 25 tap multipliers, row adders and the rounding and saturation stage.
// Depends on gb5_pkg; takes the window and its tap control from gb5_window.
module gb5_mac (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gb5_pkg::t_win     i_win,
    input  gb5_pkg::t_tap_ctl i_ctl,
    input  gb5_pkg::t_weights i_weights,
    output logic              o_valid,
    output gb5_pkg::t_result  o_result
);

    logic [gb5_pkg::PROD_W-1:0]   n_prod [gb5_pkg::KSIZE][gb5_pkg::KSIZE];
    logic [gb5_pkg::PROD_W-1:0]   r_prod [gb5_pkg::KSIZE][gb5_pkg::KSIZE];
    logic [gb5_pkg::ROWSUM_W-1:0] n_row  [gb5_pkg::KSIZE];
    logic [gb5_pkg::ROWSUM_W-1:0] r_row  [gb5_pkg::KSIZE];
    logic [gb5_pkg::SUM_W-1:0]    w_sum;
    logic [gb5_pkg::SUM_W-1:0]    w_round;
    gb5_pkg::t_result             n_res;
    gb5_pkg::t_result             r_res;
    logic                         r_prod_valid, r_prod_last;
    logic                         r_row_valid, r_row_last;
    logic                         r_res_valid;

    // Taps outside the image columns contribute nothing.
    always_comb begin
        for (int i = 0; i < gb5_pkg::KSIZE; i++) begin
            for (int j = 0; j < gb5_pkg::KSIZE; j++) begin
                n_prod[i][j] = i_ctl.mask[j] ?
                    gb5_pkg::PROD_W'(i_win[i][j]) *
                    gb5_pkg::PROD_W'(i_weights[gb5_pkg::TAP_WSEL[i][j]]) : '0;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < gb5_pkg::KSIZE; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < gb5_pkg::KSIZE; j++) begin
                n_row[i] = n_row[i] + gb5_pkg::ROWSUM_W'(r_prod[i][j]);
            end
        end
    end

    // Q8.16 sum, rounded half up to Q8.8 and clipped to the result width.
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < gb5_pkg::KSIZE; i++) begin
            w_sum = w_sum + gb5_pkg::SUM_W'(r_row[i]);
        end
        w_round = (w_sum + gb5_pkg::SUM_W'(1 << (gb5_pkg::ROUND_SHIFT - 1)))
                  >> gb5_pkg::ROUND_SHIFT;
        if (|w_round[gb5_pkg::SUM_W-1:gb5_pkg::RES_W]) begin
            n_res.blurred = '1;
        end else begin
            n_res.blurred = w_round[gb5_pkg::RES_W-1:0];
        end
        n_res.last = r_row_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_row_valid  <= 1'b0;
            r_res_valid  <= 1'b0;
        end else begin
            r_prod_valid <= i_ctl.valid;
            r_row_valid  <= r_prod_valid;
            r_res_valid  <= r_row_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod      <= n_prod;
        r_prod_last <= i_ctl.last;
        r_row       <= n_row;
        r_row_last  <= r_prod_last;
        r_res       <= n_res;
    end

    assign o_valid  = r_res_valid;
    assign o_result = r_res;

endmodule

// File: hw/rtl/gb5_out_fifo.sv
// gb5_out_fifo.sv: small result queue that decouples the datapath from the receiver.
// Depends on gb5_pkg for the depth and the result type.
module gb5_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  gb5_pkg::t_result i_wdata,
    input  logic             i_rd,
    output logic             o_valid,
    output gb5_pkg::t_result o_rdata
);

    gb5_pkg::t_result             r_mem [gb5_pkg::FIFO_DEPTH];
    logic [gb5_pkg::FIFO_AW-1:0]  r_wp, r_rp;
    logic [gb5_pkg::OCC_W-1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + gb5_pkg::FIFO_AW'(1);
            end
            if (i_rd) begin
                r_rp <= r_rp + gb5_pkg::FIFO_AW'(1);
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + gb5_pkg::OCC_W'(1);
            end else if (!i_wr && i_rd) begin
                r_cnt <= r_cnt - gb5_pkg::OCC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_mem[r_rp];

endmodule
